@@ hdl/gds_pkg.sv @@
// Package with the item types, codes and calendar helper functions of the date step unit.
package gds_pkg;

  localparam logic [13:0] YEAR_MAX = 14'd9999;

  localparam logic [1:0] ACT_NEXT_DAY  = 2'd0;
  localparam logic [1:0] ACT_PREV_DAY  = 2'd1;
  localparam logic [1:0] ACT_NEXT_YEAR = 2'd2;
  localparam logic [1:0] ACT_DAY_NUM   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_DATE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_DEC = 4'd12;

  // Reciprocal of 100 scaled by 2^19; exact for every 14-bit operand.
  localparam logic [12:0] RECIP_100  = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef struct packed {
    logic [1:0]  action;
    logic [13:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
  } gds_in_t;

  typedef struct packed {
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [21:0] serial_day;
    logic [1:0]  status;
  } gds_out_t;

  // Quotient of a 14-bit value by 100.
  function automatic logic [7:0] div100(input logic [13:0] v);
    logic [26:0] prod;
    prod = v * RECIP_100;
    return prod[RECIP_SHIFT +: 8];
  endfunction

  function automatic logic is_leap(input logic [13:0] y);
    logic [7:0]  q;
    logic [14:0] back;
    logic        cent;
    q    = div100(y);
    back = 15'(q) * 15'd100;
    cent = (back == {1'b0, y});
    return ((y[1:0] == 2'b00) && !cent) || (cent && (q[1:0] == 2'b00));
  endfunction

  // Days in a month; months outside 1 to 12 give zero.
  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days of the year before the first of a month, in a common year.
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] s;
    case (m)
      4'd1:    s = 9'd0;
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

@@ hdl/gds_core.sv @@
// Combinational date step: validity check, day and year stepping and serial day number.
module gds_core (
  input  gds_pkg::gds_in_t  item,
  output gds_pkg::gds_out_t res
);
  import gds_pkg::*;

  logic [13:0] y;
  logic [3:0]  m;
  logic [4:0]  d;
  logic        leap;
  logic [4:0]  dim;
  logic [4:0]  dim_prev;
  logic        bad;
  logic [13:0] p;
  logic [11:0] q4;
  logic [7:0]  q100;
  logic [11:0] leaps;
  logic [9:0]  doy;
  logic [21:0] base;

  assign y        = item.in_year;
  assign m        = item.in_month;
  assign d        = item.in_day;
  assign leap     = is_leap(y);
  assign dim      = days_in(m, leap);
  assign dim_prev = days_in(m - 4'd1, leap);
  assign bad      = (y == 14'd0) || (y > YEAR_MAX) || (m == 4'd0) || (m > MON_DEC) ||
                    (d == 5'd0) || (d > dim);

  // Leap years before the current one: p/4 - p/100 + p/400 with p = year - 1.
  assign p     = y - 14'd1;
  assign q4    = p[13:2];
  assign q100  = div100(p);
  assign leaps = q4 - 12'(q100) + 12'(q100[7:2]);
  assign doy   = 10'(month_start(m)) + 10'(d) + 10'((m > MON_FEB) && leap);
  assign base  = 22'(p) * 22'd365;

  always_comb begin
    res = '0;
    if (bad) begin
      res.status = ST_BAD_DATE;
    end else begin
      case (item.action)
        ACT_NEXT_DAY: begin
          if (d < dim) begin
            res.out_year  = y;
            res.out_month = m;
            res.out_day   = d + 5'd1;
          end else if (m < MON_DEC) begin
            res.out_year  = y;
            res.out_month = m + 4'd1;
            res.out_day   = 5'd1;
          end else if (y < YEAR_MAX) begin
            res.out_year  = y + 14'd1;
            res.out_month = MON_JAN;
            res.out_day   = 5'd1;
          end else begin
            res.status = ST_RANGE;
          end
        end
        ACT_PREV_DAY: begin
          if (d > 5'd1) begin
            res.out_year  = y;
            res.out_month = m;
            res.out_day   = d - 5'd1;
          end else if (m > MON_JAN) begin
            res.out_year  = y;
            res.out_month = m - 4'd1;
            res.out_day   = dim_prev;
          end else if (y > 14'd1) begin
            res.out_year  = y - 14'd1;
            res.out_month = MON_DEC;
            res.out_day   = 5'd31;
          end else begin
            res.status = ST_RANGE;
          end
        end
        ACT_NEXT_YEAR: begin
          if (y < YEAR_MAX) begin
            res.out_year  = y + 14'd1;
            res.out_month = m;
            // A leap day lands on the last day of February of the next year.
            res.out_day   = ((m == MON_FEB) && (d == 5'd29)) ? 5'd28 : d;
          end else begin
            res.status = ST_RANGE;
          end
        end
        default: begin
          res.out_year   = y;
          res.out_month  = m;
          res.out_day    = d;
          res.serial_day = base + 22'(leaps) + 22'(doy);
        end
      endcase
    end
  end

endmodule

@@ hdl/gregorian_date_step_unit.sv @@
// Top level of the Gregorian date step unit: input register, date logic and result register.
//
// An item on the in_ channel carries an action and a date (year 1 to 9999). The block
// returns one item on the out_ channel for each input item: the next day, the previous
// day, the same date one year later, or the serial day number with 1 January of year 1
// as day 1. Status flags an invalid input date or a step outside the year range; the
// date and serial fields are then zero.
// Both channels use valid and stall: an item moves on an edge where valid is high and
// stall is low. Items are taken into an input register, pass through combinational
// date logic and wait in a result register.
// out_valid rises when an item moves from the input register into the result register,
// which waits while a stalled result is held; with out_stall low, one item per cycle is
// sustained. The input register and the result register form two stages, so the block
// keeps taking items while a result waits, and raises in_stall only when both stages hold
// items and out_stall is high. A stalled result holds its value.
// Reset empties both stages; no result is pending after reset.
module gregorian_date_step_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gds_pkg::gds_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gds_pkg::gds_out_t out_data
);
  import gds_pkg::*;

  gds_in_t  in_r;
  logic     s1_valid_r;
  logic     s1_valid_nxt;
  gds_out_t out_r;
  gds_out_t res_nxt;
  logic     out_valid_r;
  logic     out_valid_nxt;
  logic     out_ready;
  logic     s1_ready;

  gds_core u_core (
    .item (in_r),
    .res  (res_nxt)
  );

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_valid_r || out_ready;
  assign in_stall  = !s1_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    s1_valid_nxt  = s1_ready ? in_valid : s1_valid_r;
    out_valid_nxt = out_ready ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      in_r <= in_data;
    end
    if (out_ready && s1_valid_r) begin
      out_r <= res_nxt;
    end
  end

  // With both stages full and the receiver stalling, no new item may enter.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("input taken while both stages are full");

  // Any error status comes with cleared date and serial fields.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status != ST_OK)) |->
      ((out_r.out_year == 14'd0) && (out_r.out_month == 4'd0) &&
       (out_r.out_day == 5'd0) && (out_r.serial_day == 22'd0)))
    else $error("error result carries nonzero fields");

  // A good result is a date inside the supported range.
  a_ok_date: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status == ST_OK)) |->
      ((out_r.out_year != 14'd0) && (out_r.out_year <= YEAR_MAX) &&
       (out_r.out_month != 4'd0) && (out_r.out_month <= MON_DEC) &&
       (out_r.out_day != 5'd0)))
    else $error("good result holds a date out of range");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("stages not empty after reset");

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for the Gregorian date step unit: directed edge dates, random dates and output hold-off.
module tb_top;
  import gds_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLDOFF_CYCLES = 60;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  gds_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  gds_out_t out_data;

  gds_out_t    pending_results[$];
  int unsigned send_gap_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned sink_hold_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned dates_sent = 0;
  int unsigned results_checked = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned bad_date_results = 0;
  int unsigned out_of_range_results = 0;
  int unsigned field_errors = 0;

  gregorian_date_step_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic bit leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Only meaningful for months 1 to 12.
  function automatic int month_length(input int y, input int m);
    case (m)
      2:            return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  function automatic gds_out_t predict_date_step(input gds_in_t d);
    gds_out_t   r;
    logic [1:0] st;
    int         y, m, dd, last, p, doy, ny, nm, nd;
    r  = '0;
    st = ST_OK;
    y  = d.in_year;
    m  = d.in_month;
    dd = d.in_day;
    ny = 0;
    nm = 0;
    nd = 0;
    if (y < 1 || y > int'(YEAR_MAX) || m < 1 || m > 12 || dd < 1 || dd > month_length(y, m)) begin
      r.status = ST_BAD_DATE;
      return r;
    end
    last = month_length(y, m);
    case (d.action)
      ACT_NEXT_DAY: begin
        if (dd < last) begin
          ny = y; nm = m; nd = dd + 1;
        end else if (m < 12) begin
          ny = y; nm = m + 1; nd = 1;
        end else if (y < int'(YEAR_MAX)) begin
          ny = y + 1; nm = 1; nd = 1;
        end else begin
          st = ST_RANGE;
        end
      end
      ACT_PREV_DAY: begin
        if (dd > 1) begin
          ny = y; nm = m; nd = dd - 1;
        end else if (m > 1) begin
          ny = y; nm = m - 1; nd = month_length(y, m - 1);
        end else if (y > 1) begin
          ny = y - 1; nm = 12; nd = 31;
        end else begin
          st = ST_RANGE;
        end
      end
      ACT_NEXT_YEAR: begin
        if (y < int'(YEAR_MAX)) begin
          ny = y + 1; nm = m;
          nd = (m == 2 && dd == 29) ? 28 : dd;
        end else begin
          st = ST_RANGE;
        end
      end
      default: begin
        // Whole years and leap days before this year, then whole months of this year, then the day.
        p = y - 1;
        doy = dd;
        for (int k = 1; k < m; k++) doy += month_length(y, k);
        r.serial_day = 22'(365 * p + p / 4 - p / 100 + p / 400 + doy);
        ny = y; nm = m; nd = dd;
      end
    endcase
    if (st == ST_OK) begin
      r.out_year  = 14'(ny);
      r.out_month = 4'(nm);
      r.out_day   = 5'(nd);
    end
    r.status = st;
    return r;
  endfunction

  function automatic gds_in_t date_item(input logic [1:0] act, input int y, input int m,
                                        input int dd);
    gds_in_t d;
    d.action   = act;
    d.in_year  = 14'(y);
    d.in_month = 4'(m);
    d.in_day   = 5'(dd);
    return d;
  endfunction

  // Mostly well-formed dates, a good share near month, year and range edges, the rest raw bits.
  function automatic gds_in_t random_date();
    gds_in_t d;
    int      pick, y, m;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      y = $urandom_range(1, 9999);
      m = $urandom_range(1, 12);
      d = date_item(2'($urandom_range(0, 3)), y, m, $urandom_range(1, month_length(y, m)));
    end else if (pick < 82) begin
      case ($urandom_range(0, 5))
        0:       y = 1;
        1:       y = 9999;
        2:       y = 100 * $urandom_range(1, 99);
        3:       y = 400 * $urandom_range(1, 24);
        4:       y = 4 * $urandom_range(1, 2499);
        default: y = $urandom_range(1, 9999);
      endcase
      case ($urandom_range(0, 3))
        0:       m = 1;
        1:       m = 2;
        2:       m = 12;
        default: m = $urandom_range(1, 12);
      endcase
      d = date_item(2'($urandom_range(0, 3)), y, m,
                    ($urandom_range(0, 1) != 0) ? 1 : month_length(y, m));
    end else begin
      d = gds_in_t'(25'($urandom));
    end
    return d;
  endfunction

  task automatic send_date(input gds_in_t item);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    pending_results.push_back(predict_date_step(item));
    dates_sent++;
  endtask

  always @(posedge clk) begin
    if (sink_hold_cycles != 0) begin
      out_stall <= 1'b1;
      sink_hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    gds_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result item arrived with no date pending");
        field_errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_data.out_year !== want.out_year) begin
          $error("out_year: expected %0d, got %0d", want.out_year, out_data.out_year);
          field_errors++;
        end
        if (out_data.out_month !== want.out_month) begin
          $error("out_month: expected %0d, got %0d", want.out_month, out_data.out_month);
          field_errors++;
        end
        if (out_data.out_day !== want.out_day) begin
          $error("out_day: expected %0d, got %0d", want.out_day, out_data.out_day);
          field_errors++;
        end
        if (out_data.serial_day !== want.serial_day) begin
          $error("serial_day: expected %0d, got %0d", want.serial_day, out_data.serial_day);
          field_errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          field_errors++;
        end
        if (want.status == ST_BAD_DATE) bad_date_results++;
        if (want.status == ST_RANGE) out_of_range_results++;
      end
    end
  end

  task automatic test_calendar_edges();
    send_date(date_item(ACT_DAY_NUM,   1,    1,  1));
    send_date(date_item(ACT_DAY_NUM,   9999, 12, 31));
    send_date(date_item(ACT_NEXT_DAY,  9999, 12, 31));
    send_date(date_item(ACT_PREV_DAY,  1,    1,  1));
    send_date(date_item(ACT_NEXT_YEAR, 9999, 6,  15));
    send_date(date_item(ACT_NEXT_YEAR, 2000, 2,  29));
    send_date(date_item(ACT_PREV_DAY,  2000, 3,  1));
    send_date(date_item(ACT_PREV_DAY,  1900, 3,  1));
    send_date(date_item(ACT_NEXT_DAY,  2024, 2,  28));
    send_date(date_item(ACT_NEXT_DAY,  2023, 2,  28));
    // On the first of January the previous day falls in December of the year before.
    send_date(date_item(ACT_PREV_DAY,  2021, 1,  1));
    send_date(date_item(ACT_NEXT_DAY,  1999, 12, 31));
    send_date(date_item(ACT_NEXT_DAY,  2000, 4,  30));
    send_date(date_item(ACT_NEXT_DAY,  0,    5,  5));
    send_date(date_item(ACT_PREV_DAY,  16383, 15, 31));
    send_date(date_item(ACT_NEXT_YEAR, 2010, 0,  10));
    send_date(date_item(ACT_DAY_NUM,   2010, 13, 10));
    send_date(date_item(ACT_NEXT_DAY,  2010, 7,  0));
    send_date(date_item(ACT_PREV_DAY,  2010, 4,  31));
    send_date(date_item(ACT_NEXT_DAY,  1900, 2,  29));
    send_date(date_item(ACT_DAY_NUM,   2000, 2,  30));
    // The leap count must only include the years before the current one.
    send_date(date_item(ACT_DAY_NUM,   2000, 3,  1));
    send_date(date_item(ACT_DAY_NUM,   1600, 12, 31));
    send_date(date_item(ACT_NEXT_YEAR, 2023, 2,  28));
    send_date(date_item(ACT_DAY_NUM,   10000, 1, 1));
  endtask

  task automatic test_random_dates(input int unsigned count);
    repeat (count) send_date(random_date());
  endtask

  // Hold the output off while dates keep coming so the block fills and stalls its input.
  task automatic test_output_holdoff();
    send_gap_pct = 0;
    sink_hold_cycles = HOLDOFF_CYCLES;
    repeat (24) send_date(random_date());
  endtask

  initial begin
    send_gap_pct   = 25;
    sink_stall_pct = 73;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_calendar_edges();
    test_random_dates(135);
    send_gap_pct   = 73;
    sink_stall_pct = 25;
    test_random_dates(125);
    test_output_holdoff();
    send_gap_pct   = 0;
    sink_stall_pct = 0;
    test_random_dates(120);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    $display("Checked %0d results for %0d dates: %0d invalid dates, %0d steps out of range.",
             results_checked, dates_sent, bad_date_results, out_of_range_results);
    $display("Sender and receiver idling swapped between phases; input stalled %0d cycles.",
             input_stall_cycles);
    if (field_errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
